FILE: rtl/foccl_pkg.sv
// Shared types and constants of the field-oriented current loop.
// Used by every module under rtl/; depends on nothing else.
package foccl_pkg;

    // Datapath widths of the serial units; they cover every fraction width the block supports.
    localparam int OPA_W     = 36;
    localparam int OPB_W     = 18;
    localparam int ACC_W     = 54;
    localparam int V_W       = 20;
    localparam int BUSF_W    = 24;
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_Q_W   = 18;
    localparam int ROM_W     = 16;
    localparam int IDX_W     = 3;

    // Fixed scale factors.
    localparam int INV_SQRT3_Q16  = 37837;
    localparam int HALF_SQRT3_Q16 = 56756;
    localparam int HALF_Q16       = 32768;

    // Sine series constants: pi in Q30 and the divisors (2n)(2n+1) of the Taylor terms.
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [7:0] SERIES_DIV [0:6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_D_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_Q_TARGET = 3'd1;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_BUS      = 3'd5;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd6;

    // Register values after reset.
    localparam logic [15:0] RST_D_TARGET = 16'd0;
    localparam logic [15:0] RST_Q_TARGET = 16'd2048;
    localparam logic [15:0] RST_KP       = 16'd2048;
    localparam logic [15:0] RST_KI       = 16'd41;
    localparam logic [14:0] RST_LIMIT    = 15'd4096;
    localparam logic [15:0] RST_BUS      = 16'd3072;
    localparam logic [15:0] RST_PERIOD   = 16'd1000;

    // Command to the serial multiply-accumulate unit.
    typedef struct packed {
        logic start;
        logic accumulate;
    } t_mul_cmd;

endpackage

FILE: rtl/foccl_ser_mul.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
// Depends on foccl_pkg.
module foccl_ser_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  foccl_pkg::t_mul_cmd                 i_cmd,
    input  logic signed [foccl_pkg::OPA_W-1:0]  i_a,
    input  logic signed [foccl_pkg::OPB_W-1:0]  i_b,
    output logic                                o_busy,
    output logic signed [foccl_pkg::ACC_W-1:0]  o_acc
);
    localparam int CNT_W = $clog2(foccl_pkg::OPB_W + 1);

    logic signed [foccl_pkg::ACC_W-1:0] r_a;
    logic signed [foccl_pkg::ACC_W-1:0] r_acc;
    logic signed [foccl_pkg::ACC_W-1:0] w_addend;
    logic [foccl_pkg::OPB_W-1:0]        r_b;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_busy;
    logic                               w_last;

    // The top multiplier bit carries negative weight, so it subtracts.
    assign w_last   = (r_cnt == CNT_W'(1));
    assign w_addend = w_last ? -r_a : r_a;
    assign o_busy   = r_busy;
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(foccl_pkg::OPB_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= foccl_pkg::ACC_W'(i_a);
            r_b <= i_b;
            if (!i_cmd.accumulate) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + w_addend;
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

endmodule

FILE: rtl/foccl_ser_div.sv
// Restoring divider, one quotient bit per cycle, result saturated to the PWM period.
// Depends on foccl_pkg.
module foccl_ser_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [foccl_pkg::DIV_NUM_W-1:0]   i_numer,
    input  logic [foccl_pkg::DIV_DEN_W-1:0]   i_den,
    input  logic [15:0]                       i_period,
    output logic                              o_busy,
    output logic [15:0]                       o_quot
);
    localparam int CNT_W = $clog2(foccl_pkg::DIV_Q_W + 1);

    logic [foccl_pkg::DIV_NUM_W-1:0] r_rem;
    logic [foccl_pkg::DIV_NUM_W-1:0] r_dsh;
    logic [foccl_pkg::DIV_NUM_W-1:0] w_den_full;
    logic [foccl_pkg::DIV_Q_W-1:0]   r_q;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_busy;
    logic                            r_sat;
    logic                            w_ge;

    assign w_den_full = foccl_pkg::DIV_NUM_W'(i_den) << foccl_pkg::DIV_Q_W;
    assign w_ge       = (r_rem >= r_dsh);
    assign o_busy     = r_busy;
    // A quotient too wide for the register is certainly above the period.
    assign o_quot     = (r_sat || (r_q >= foccl_pkg::DIV_Q_W'(i_period))) ? i_period
                                                                           : r_q[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(foccl_pkg::DIV_Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_numer;
            r_dsh <= foccl_pkg::DIV_NUM_W'(i_den) << (foccl_pkg::DIV_Q_W - 1);
            r_q   <= '0;
            r_sat <= (i_numer >= w_den_full);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[foccl_pkg::DIV_Q_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

FILE: rtl/foccl_sine_lut.sv
// Quarter-wave sine table and quadrant unfolding for the rotor angle.
// Depends on foccl_pkg; the table is computed at elaboration from a Taylor series.
module foccl_sine_lut #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FRACTION_BITS    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [16:0] o_sin,
    output logic signed [16:0] o_cos
);
    localparam int K_W          = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int HALF_TURN_DIV = 2 * SINE_TABLE_DEPTH;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RD_A = 2'd1;
    localparam logic [1:0] PH_RD_B = 2'd2;
    localparam logic [1:0] PH_FORM = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef logic [foccl_pkg::ROM_W-1:0] t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom build_sine();
        t_rom               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (64'(k) * foccl_pkg::PI_Q30) / HALF_TURN_DIV;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / foccl_pkg::SERIES_DIV[n-1];
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = foccl_pkg::ROM_W'((64'(sum) + (64'd1 << (29 - FRACTION_BITS)))
                                       >> (30 - FRACTION_BITS));
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_sine();

    logic [1:0]                  r_ph;
    logic [1:0]                  r_quad;
    logic [K_W-1:0]              r_k;
    logic [K_W-1:0]              w_addr;
    logic [14+K_W-1:0]           w_prod;
    logic [foccl_pkg::ROM_W-1:0] r_rd;
    logic [foccl_pkg::ROM_W-1:0] r_a;
    logic signed [16:0]          w_a;
    logic signed [16:0]          w_b;
    logic                        r_done;
    logic signed [16:0]          r_sin;
    logic signed [16:0]          r_cos;

    assign w_prod = (14+K_W)'(i_angle[13:0]) * (14+K_W)'(SINE_TABLE_DEPTH);
    assign w_addr = (r_ph == PH_RD_A) ? r_k : (K_W'(SINE_TABLE_DEPTH) - r_k);
    assign w_a    = signed'({1'b0, r_a});
    assign w_b    = signed'({1'b0, r_rd});
    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ph <= PH_RD_A;
                    end
                end
                PH_RD_A: r_ph <= PH_RD_B;
                PH_RD_B: r_ph <= PH_FORM;
                PH_FORM: begin
                    r_ph   <= PH_IDLE;
                    r_done <= 1'b1;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_quad <= i_angle[15:14];
            r_k    <= w_prod[14+K_W-1:14];
        end
        if (r_ph == PH_RD_A || r_ph == PH_RD_B) begin
            r_rd <= SINE_ROM[w_addr];
        end
        if (r_ph == PH_RD_B) begin
            r_a <= r_rd;
        end
        if (r_ph == PH_FORM) begin
            case (r_quad)
                QUAD_0: begin
                    r_sin <= w_a;
                    r_cos <= w_b;
                end
                QUAD_1: begin
                    r_sin <= w_b;
                    r_cos <= -w_a;
                end
                QUAD_2: begin
                    r_sin <= -w_a;
                    r_cos <= -w_b;
                end
                default: begin
                    r_sin <= -w_b;
                    r_cos <= w_a;
                end
            endcase
        end
    end

endmodule

FILE: rtl/foc_current_loop.sv
// Top level of the field-oriented current loop: sequencer, PI state and result register.
// Depends on foccl_pkg, foccl_sine_lut, foccl_ser_mul and foccl_ser_div.
//
// Usage. An input word (two phase currents and the rotor angle) is taken on the input
// channel when i_in_valid and o_in_ready are both high; o_in_ready is high only while the
// sequencer is idle, so one word is processed at a time. Each word yields exactly one
// output word: three PWM compare values and the measured d and q currents.
// The configuration channel takes a register index and data whenever i_cfg_valid is high;
// registers should only be written while no word is in flight.
// Per word, the angle lookup runs first, then twenty multiply-accumulate steps run on one
// bit-serial multiplier, and a serial division yields each compare value whose numerator
// is positive; the others are set to zero. Most of the time per word is spent in the
// shared serial multiplier.
// The finished word sits in an output register. A new input word is accepted while it
// waits; if the receiver still stalls when the next word is finished, the sequencer holds
// that word until the register is free, and nothing is lost.
// Reset (synchronous, active low) restores the register defaults, clears both integrators
// and empties the output register.
module foc_current_loop #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FRACTION_BITS    = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [15:0]                  i_phase_u_current,
    input  logic signed [15:0]                  i_phase_v_current,
    input  logic [15:0]                         i_rotor_angle,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [15:0]                         o_duty_a,
    output logic [15:0]                         o_duty_b,
    output logic [15:0]                         o_duty_c,
    output logic signed [15:0]                  o_d_current,
    output logic signed [15:0]                  o_q_current,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [foccl_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);
    localparam int ACC_W = foccl_pkg::ACC_W;
    localparam int OPA_W = foccl_pkg::OPA_W;
    localparam int OPB_W = foccl_pkg::OPB_W;
    localparam int V_W   = foccl_pkg::V_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRIG  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Multiply-accumulate steps, run in this order.
    localparam logic [4:0] OP_BETA = 5'd0;
    localparam logic [4:0] OP_D0   = 5'd1;
    localparam logic [4:0] OP_D1   = 5'd2;
    localparam logic [4:0] OP_Q0   = 5'd3;
    localparam logic [4:0] OP_Q1   = 5'd4;
    localparam logic [4:0] OP_ID   = 5'd5;
    localparam logic [4:0] OP_PD   = 5'd6;
    localparam logic [4:0] OP_IQ   = 5'd7;
    localparam logic [4:0] OP_PQ   = 5'd8;
    localparam logic [4:0] OP_VA0  = 5'd9;
    localparam logic [4:0] OP_VA1  = 5'd10;
    localparam logic [4:0] OP_VB0  = 5'd11;
    localparam logic [4:0] OP_VB1  = 5'd12;
    localparam logic [4:0] OP_PB0  = 5'd13;
    localparam logic [4:0] OP_PB1  = 5'd14;
    localparam logic [4:0] OP_PC0  = 5'd15;
    localparam logic [4:0] OP_PC1  = 5'd16;
    localparam logic [4:0] OP_NA   = 5'd17;
    localparam logic [4:0] OP_NB   = 5'd18;
    localparam logic [4:0] OP_NC   = 5'd19;

    localparam logic signed [OPB_W-1:0] B_INV_SQRT3  = OPB_W'(foccl_pkg::INV_SQRT3_Q16);
    localparam logic signed [OPB_W-1:0] B_HALF_SQRT3 = OPB_W'(foccl_pkg::HALF_SQRT3_Q16);
    localparam logic signed [OPB_W-1:0] B_HALF       = OPB_W'(foccl_pkg::HALF_Q16);

    localparam logic signed [ACC_W-1:0] HALF_F  = ACC_W'(1) << (FRACTION_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_16 = ACC_W'(1) << 15;
    localparam logic signed [ACC_W-1:0] MAX16   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MIN16   = ACC_W'(-32768);

    // Saturate a wide signed value to the 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > MAX16) begin
            r = 16'sd32767;
        end else if (v < MIN16) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp a wide signed value to plus or minus the regulator limit.
    function automatic logic signed [15:0] clampsym(input logic signed [ACC_W-1:0] v,
                                                   input logic [14:0] lim);
        logic signed [ACC_W-1:0] l;
        logic signed [15:0]      r;
        l = ACC_W'(lim);
        if (v > l) begin
            r = l[15:0];
        end else if (v < -l) begin
            r = -l[15:0];
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Control and configuration.
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [4:0]         r_op;
    logic [4:0]         n_op;
    logic               r_out_valid;
    logic signed [15:0] r_tgt_d;
    logic signed [15:0] r_tgt_q;
    logic [15:0]        r_kp;
    logic [15:0]        r_ki;
    logic [14:0]        r_lim;
    logic [15:0]        r_bus;
    logic [15:0]        r_period;
    logic signed [15:0] r_dint;
    logic signed [15:0] r_qint;

    // Per-word working registers.
    logic signed [15:0]  r_iu;
    logic signed [15:0]  r_iv;
    logic signed [16:0]  r_s;
    logic signed [16:0]  r_c;
    logic signed [17:0]  r_beta;
    logic signed [15:0]  r_d;
    logic signed [15:0]  r_q;
    logic signed [15:0]  r_vd;
    logic signed [15:0]  r_vq;
    logic signed [V_W-1:0] r_va;
    logic signed [V_W-1:0] r_vb;
    logic signed [V_W-1:0] r_pb;
    logic signed [V_W-1:0] r_pc;
    logic [15:0]         r_wa;
    logic [15:0]         r_wb;
    logic [15:0]         r_wc;

    // Output register.
    logic [15:0]         r_duty_a;
    logic [15:0]         r_duty_b;
    logic [15:0]         r_duty_c;
    logic signed [15:0]  r_dcur;
    logic signed [15:0]  r_qcur;

    // Datapath signals.
    logic                        w_accept;
    logic                        w_trig_done;
    logic signed [16:0]          w_sin;
    logic signed [16:0]          w_cos;
    foccl_pkg::t_mul_cmd         w_mul_cmd;
    logic signed [OPA_W-1:0]     w_a;
    logic signed [OPB_W-1:0]     w_b;
    logic                        w_mul_busy;
    logic signed [ACC_W-1:0]     w_acc;
    logic signed [ACC_W-1:0]     w_rf;
    logic signed [ACC_W-1:0]     w_r16;
    logic signed [16:0]          w_err_d;
    logic signed [16:0]          w_err_q;
    logic [15:0]                 w_bus_eff;
    logic [foccl_pkg::BUSF_W-1:0] w_busf;
    logic signed [OPA_W-1:0]     w_busf_a;
    logic                        w_mul_fin;
    logic                        w_is_n_op;
    logic                        w_num_nonpos;
    logic                        w_div_start;
    logic                        w_div_busy;
    logic [15:0]                 w_quot;
    logic                        w_load_out;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Rounding shift, half up, by the fraction width and by sixteen.
    assign w_rf  = (w_acc + HALF_F) >>> FRACTION_BITS;
    assign w_r16 = (w_acc + HALF_16) >>> 16;

    assign w_err_d = 17'(r_tgt_d) - 17'(r_d);
    assign w_err_q = 17'(r_tgt_q) - 17'(r_q);

    // A zero bus voltage counts as one LSB; the bus is rescaled to the current format.
    assign w_bus_eff = (r_bus == 16'd0) ? 16'd1 : r_bus;
    assign w_busf    = foccl_pkg::BUSF_W'(w_bus_eff) << (FRACTION_BITS - 8);
    assign w_busf_a  = OPA_W'(w_busf);

    assign w_mul_fin    = (r_state == S_WAIT) && !w_mul_busy;
    assign w_is_n_op    = (r_op == OP_NA) || (r_op == OP_NB) || (r_op == OP_NC);
    assign w_num_nonpos = w_acc[ACC_W-1] || (w_acc == '0);
    assign w_div_start  = w_mul_fin && w_is_n_op && !w_num_nonpos;
    assign w_load_out   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign w_mul_cmd.start      = (r_state == S_ISSUE);
    assign w_mul_cmd.accumulate = (r_op == OP_D1) || (r_op == OP_Q1) || (r_op == OP_VA1) ||
                                  (r_op == OP_VB1) || (r_op == OP_PB1) || (r_op == OP_PC1);

    // Operand selection for each step.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_op)
            OP_BETA: begin
                w_a = OPA_W'(r_iu) + (OPA_W'(r_iv) <<< 1);
                w_b = B_INV_SQRT3;
            end
            OP_D0: begin
                w_a = OPA_W'(r_iu);
                w_b = OPB_W'(r_c);
            end
            OP_D1: begin
                w_a = OPA_W'(r_beta);
                w_b = OPB_W'(r_s);
            end
            OP_Q0: begin
                w_a = -OPA_W'(r_iu);
                w_b = OPB_W'(r_s);
            end
            OP_Q1: begin
                w_a = OPA_W'(r_beta);
                w_b = OPB_W'(r_c);
            end
            OP_ID: begin
                w_a = OPA_W'(w_err_d);
                w_b = OPB_W'(r_ki);
            end
            OP_PD: begin
                w_a = OPA_W'(w_err_d);
                w_b = OPB_W'(r_kp);
            end
            OP_IQ: begin
                w_a = OPA_W'(w_err_q);
                w_b = OPB_W'(r_ki);
            end
            OP_PQ: begin
                w_a = OPA_W'(w_err_q);
                w_b = OPB_W'(r_kp);
            end
            OP_VA0: begin
                w_a = OPA_W'(r_vd);
                w_b = OPB_W'(r_c);
            end
            OP_VA1: begin
                w_a = -OPA_W'(r_vq);
                w_b = OPB_W'(r_s);
            end
            OP_VB0: begin
                w_a = OPA_W'(r_vd);
                w_b = OPB_W'(r_s);
            end
            OP_VB1: begin
                w_a = OPA_W'(r_vq);
                w_b = OPB_W'(r_c);
            end
            OP_PB0: begin
                w_a = -OPA_W'(r_va);
                w_b = B_HALF;
            end
            OP_PB1: begin
                w_a = OPA_W'(r_vb);
                w_b = B_HALF_SQRT3;
            end
            OP_PC0: begin
                w_a = -OPA_W'(r_va);
                w_b = B_HALF;
            end
            OP_PC1: begin
                w_a = -OPA_W'(r_vb);
                w_b = B_HALF_SQRT3;
            end
            OP_NA: begin
                w_a = (OPA_W'(r_va) <<< 1) + w_busf_a;
                w_b = OPB_W'(r_period);
            end
            OP_NB: begin
                w_a = (OPA_W'(r_pb) <<< 1) + w_busf_a;
                w_b = OPB_W'(r_period);
            end
            OP_NC: begin
                w_a = (OPA_W'(r_pc) <<< 1) + w_busf_a;
                w_b = OPB_W'(r_period);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                if (w_trig_done) begin
                    n_state = S_ISSUE;
                    n_op    = OP_BETA;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (!w_mul_busy) begin
                    if (w_div_start) begin
                        n_state = S_DIV;
                    end else if (r_op == OP_NC) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                        n_op    = r_op + 5'd1;
                    end
                end
            end
            S_DIV: begin
                if (!w_div_busy) begin
                    if (r_op == OP_NC) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                        n_op    = r_op + 5'd1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration registers and the PI integrators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_BETA;
            r_out_valid <= 1'b0;
            r_tgt_d     <= signed'(foccl_pkg::RST_D_TARGET);
            r_tgt_q     <= signed'(foccl_pkg::RST_Q_TARGET);
            r_kp        <= foccl_pkg::RST_KP;
            r_ki        <= foccl_pkg::RST_KI;
            r_lim       <= foccl_pkg::RST_LIMIT;
            r_bus       <= foccl_pkg::RST_BUS;
            r_period    <= foccl_pkg::RST_PERIOD;
            r_dint      <= '0;
            r_qint      <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    foccl_pkg::REG_D_TARGET: r_tgt_d  <= signed'(i_cfg_data);
                    foccl_pkg::REG_Q_TARGET: r_tgt_q  <= signed'(i_cfg_data);
                    foccl_pkg::REG_KP:       r_kp     <= i_cfg_data;
                    foccl_pkg::REG_KI:       r_ki     <= i_cfg_data;
                    foccl_pkg::REG_LIMIT:    r_lim    <= i_cfg_data[14:0];
                    foccl_pkg::REG_BUS:      r_bus    <= i_cfg_data;
                    foccl_pkg::REG_PERIOD:   r_period <= i_cfg_data;
                    default: ;
                endcase
            end
            // The integrator is clamped to the limit in force at this step.
            if (w_mul_fin && r_op == OP_ID) begin
                r_dint <= clampsym(ACC_W'(r_dint) + w_rf, r_lim);
            end
            if (w_mul_fin && r_op == OP_IQ) begin
                r_qint <= clampsym(ACC_W'(r_qint) + w_rf, r_lim);
            end
        end
    end

    // Working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_iu <= i_phase_u_current;
            r_iv <= i_phase_v_current;
        end
        if (r_state == S_TRIG && w_trig_done) begin
            r_s <= w_sin;
            r_c <= w_cos;
        end
        if (w_mul_fin) begin
            case (r_op)
                OP_BETA: r_beta <= w_r16[17:0];
                OP_D1:   r_d    <= sat16(w_rf);
                OP_Q1:   r_q    <= sat16(w_rf);
                OP_PD:   r_vd   <= clampsym(w_rf + ACC_W'(r_dint), r_lim);
                OP_PQ:   r_vq   <= clampsym(w_rf + ACC_W'(r_qint), r_lim);
                OP_VA1:  r_va   <= w_rf[V_W-1:0];
                OP_VB1:  r_vb   <= w_rf[V_W-1:0];
                OP_PB1:  r_pb   <= w_r16[V_W-1:0];
                OP_PC1:  r_pc   <= w_r16[V_W-1:0];
                OP_NA: begin
                    if (w_num_nonpos) begin
                        r_wa <= 16'd0;
                    end
                end
                OP_NB: begin
                    if (w_num_nonpos) begin
                        r_wb <= 16'd0;
                    end
                end
                OP_NC: begin
                    if (w_num_nonpos) begin
                        r_wc <= 16'd0;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_DIV && !w_div_busy) begin
            case (r_op)
                OP_NA:   r_wa <= w_quot;
                OP_NB:   r_wb <= w_quot;
                default: r_wc <= w_quot;
            endcase
        end
        if (w_load_out) begin
            r_duty_a <= r_wa;
            r_duty_b <= r_wb;
            r_duty_c <= r_wc;
            r_dcur   <= r_d;
            r_qcur   <= r_q;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty_a    = r_duty_a;
    assign o_duty_b    = r_duty_b;
    assign o_duty_c    = r_duty_c;
    assign o_d_current = r_dcur;
    assign o_q_current = r_qcur;

    foccl_sine_lut #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_sine_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_angle (i_rotor_angle),
        .o_done  (w_trig_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    foccl_ser_mul u_ser_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mul_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_busy  (w_mul_busy),
        .o_acc   (w_acc)
    );

    // Compare value = (num + busf) / (2 * busf), which rounds num / (2 * busf) half up.
    foccl_ser_div u_ser_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_numer  (w_acc[foccl_pkg::DIV_NUM_W-1:0]
                   + foccl_pkg::DIV_NUM_W'(w_busf)),
        .i_den    ({w_busf, 1'b0}),
        .i_period (r_period),
        .o_busy   (w_div_busy),
        .o_quot   (w_quot)
    );

`ifndef SYNTHESIS
    a_mul_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_cmd.start |-> !w_mul_busy)
        else $error("multiplier started while busy");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_div_only_for_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_op == OP_NA || r_op == OP_NB || r_op == OP_NC))
        else $error("division outside a compare value step");

    a_units_quiet_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_mul_busy && !w_div_busy))
        else $error("input ready while a serial unit still works");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && r_state != S_DONE) |=> !o_out_valid)
        else $error("output word repeated after acceptance");
`endif

endmodule
